// File: rtl/text_console_writer_core_defines.svh
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

// same-cycle implication
`define TCW_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tcw_pkg.sv
package tcw_pkg;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int KIND_W = 3;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_PUT       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READ      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SET_CUR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BACKSPACE = 3'd4;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ERROR     = 8'h45;

    localparam logic [1:0] REG_TEXT_ATTR    = 2'd0;
    localparam logic [1:0] REG_DEFAULT_ATTR = 2'd1;
    localparam logic [1:0] REG_ERROR_ATTR   = 2'd2;

    localparam logic [ATTR_W-1:0] TEXT_ATTR_RST    = 8'd15;
    localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd15;
    localparam logic [ATTR_W-1:0] ERROR_ATTR_RST   = 8'd244;

    localparam logic [2:0] MEM_NONE         = 3'd0;
    localparam logic [2:0] MEM_EXEC         = 3'd1;
    localparam logic [2:0] MEM_FILL         = 3'd2;
    localparam logic [2:0] MEM_SCROLL_PRIME = 3'd3;
    localparam logic [2:0] MEM_SCROLL       = 3'd4;

    typedef struct packed {
        logic [ATTR_W-1:0] text_attr;
        logic [ATTR_W-1:0] default_attr;
        logic [ATTR_W-1:0] error_attr;
    } cfg_t;

    typedef struct packed {
        logic              keep_cursor;
        logic              use_position;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic [CHAR_W-1:0] char_code;
        logic [KIND_W-1:0] kind;
    } item_t;

    typedef struct packed {
        logic              scrolled;
        logic              position_error;
        logic [ATTR_W-1:0] cell_attr;
        logic [CHAR_W-1:0] cell_char;
        logic [ROW_W-1:0]  next_row;
        logic [COL_W-1:0]  next_column;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_column;
    } result_t;

    typedef struct packed {
        logic       load;
        logic       plan;
        logic [2:0] mem_op;
        logic       fill_blank;
        logic       out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic plan_clear;
        logic plan_scroll;
        logic walk_last;
        logic out_busy;
    } dp_status_t;

endpackage

// File: rtl/tcw_regs.sv
module tcw_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output tcw_pkg::cfg_t                    cfg
);

    logic [tcw_pkg::ATTR_W-1:0] text_attr_reg;
    logic [tcw_pkg::ATTR_W-1:0] default_attr_reg;
    logic [tcw_pkg::ATTR_W-1:0] error_attr_reg;
    logic [1:0]                 index;
    logic                       wr_en;

    assign index  = paddr[3:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_attr_reg    <= tcw_pkg::TEXT_ATTR_RST;
            default_attr_reg <= tcw_pkg::DEFAULT_ATTR_RST;
            error_attr_reg   <= tcw_pkg::ERROR_ATTR_RST;
        end else if (wr_en) begin
            unique case (index)
                tcw_pkg::REG_TEXT_ATTR:    text_attr_reg    <= pwdata[7:0];
                tcw_pkg::REG_DEFAULT_ATTR: default_attr_reg <= pwdata[7:0];
                tcw_pkg::REG_ERROR_ATTR:   error_attr_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (index)
            tcw_pkg::REG_TEXT_ATTR:    prdata = {24'd0, text_attr_reg};
            tcw_pkg::REG_DEFAULT_ATTR: prdata = {24'd0, default_attr_reg};
            tcw_pkg::REG_ERROR_ATTR:   prdata = {24'd0, error_attr_reg};
            default:                   prdata = '0;
        endcase
    end

    assign cfg.text_attr    = text_attr_reg;
    assign cfg.default_attr = default_attr_reg;
    assign cfg.error_attr   = error_attr_reg;

endmodule

// File: rtl/tcw_datapath.sv
module tcw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tcw_pkg::cfg_t        cfg,
    input  tcw_pkg::item_t       item,
    input  tcw_pkg::ctrl_cmd_t   cmd,
    output tcw_pkg::dp_status_t  st,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tcw_pkg::result_t     result
);

    localparam int CELLS       = COLUMNS * ROWS;
    localparam int SHIFT_CELLS = CELLS - COLUMNS;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int COL_W       = tcw_pkg::COL_W;
    localparam int ROW_W       = tcw_pkg::ROW_W;
    localparam int CELL_W      = tcw_pkg::CELL_W;

    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [ROW_W:0]    ROW_END    = (ROW_W + 1)'(ROWS);
    localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ADDR_SHIFT = ADDR_W'(SHIFT_CELLS);
    localparam logic [ADDR_W-1:0] ADDR_PREF  = ADDR_W'(SHIFT_CELLS - 1);
    localparam logic [ADDR_W-1:0] ADDR_ROW1  = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] ADDR_AHEAD = ADDR_W'(COLUMNS + 1);

    tcw_pkg::item_t item_reg;

    logic [COL_W-1:0] cur_col_reg;
    logic [ROW_W-1:0] cur_row_reg;

    logic [ADDR_W-1:0] addr_reg;
    logic [CELL_W-1:0] wdata_reg;
    logic              plan_wr_reg;
    logic              plan_rd_reg;
    logic              plan_clear_reg;
    logic              plan_scroll_reg;
    logic              plan_perr_reg;
    logic [COL_W-1:0]  plan_cur_col_reg;
    logic [ROW_W-1:0]  plan_cur_row_reg;
    logic [COL_W-1:0]  plan_nxt_col_reg;
    logic [ROW_W-1:0]  plan_nxt_row_reg;

    logic [ADDR_W-1:0] idx_reg;
    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;

    logic              m_valid_reg;
    tcw_pkg::result_t  result_reg;

    logic                       in_range;
    logic [COL_W-1:0]           tc;
    logic [ROW_W-1:0]           tr;
    logic [COL_W-1:0]           nc;
    logic [ROW_W:0]             nr_ext;
    logic [ROW_W-1:0]           nr;
    logic [COL_W-1:0]           ac;
    logic [ROW_W-1:0]           ar;
    logic [COL_W-1:0]           bc;
    logic [ROW_W-1:0]           br;
    logic                       wr;
    logic                       rd;
    logic                       clr;
    logic                       scr;
    logic                       perr;
    logic                       next_set;
    logic [COL_W-1:0]           ncur_col;
    logic [ROW_W-1:0]           ncur_row;
    logic [COL_W-1:0]           nxt_col;
    logic [ROW_W-1:0]           nxt_row;
    logic [tcw_pkg::ATTR_W-1:0] wattr;
    logic [CELL_W-1:0]          wdata;
    logic [ADDR_W-1:0]          addr_calc;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              walk_step;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= item;
        end
    end

    assign in_range = (item_reg.column < COL_W'(COLUMNS)) && (item_reg.row < ROW_W'(ROWS));
    assign tc       = item_reg.use_position ? item_reg.column : cur_col_reg;
    assign tr       = item_reg.use_position ? item_reg.row : cur_row_reg;
    assign wattr    = (cfg.text_attr != '0) ? cfg.text_attr : cfg.default_attr;
    assign bc       = (cur_col_reg != '0) ? cur_col_reg - COL_W'(1) : COL_LAST;
    assign br       = (cur_col_reg != '0) ? cur_row_reg : cur_row_reg - ROW_W'(1);

    always_comb begin
        ac       = tc;
        ar       = tr;
        wr       = 1'b0;
        rd       = 1'b0;
        clr      = 1'b0;
        scr      = 1'b0;
        perr     = 1'b0;
        next_set = 1'b0;
        ncur_col = cur_col_reg;
        ncur_row = cur_row_reg;
        nxt_col  = cur_col_reg;
        nxt_row  = cur_row_reg;
        nc       = tc;
        nr_ext   = {1'b0, tr};
        nr       = tr;
        wdata    = {wattr, item_reg.char_code};
        unique case (item_reg.kind)
            tcw_pkg::KIND_PUT: begin
                if (item_reg.use_position && !in_range) begin
                    ac       = COL_LAST;
                    ar       = ROW_LAST;
                    wr       = 1'b1;
                    perr     = 1'b1;
                    wdata    = {cfg.error_attr, tcw_pkg::CHAR_ERROR};
                    next_set = 1'b1;
                    nxt_col  = item_reg.column;
                    nxt_row  = item_reg.row;
                end else begin
                    if (item_reg.char_code == tcw_pkg::CHAR_NEWLINE) begin
                        nc     = '0;
                        nr_ext = {1'b0, tr} + (ROW_W + 1)'(1);
                    end else if (item_reg.char_code == tcw_pkg::CHAR_BACKSPACE) begin
                        wr    = 1'b1;
                        wdata = {wattr, tcw_pkg::CHAR_SPACE};
                    end else begin
                        wr = 1'b1;
                        if (tc == COL_LAST) begin
                            nc     = '0;
                            nr_ext = {1'b0, tr} + (ROW_W + 1)'(1);
                        end else begin
                            nc = tc + COL_W'(1);
                        end
                    end
                    if (nr_ext == ROW_END) begin
                        scr = 1'b1;
                        nr  = ROW_LAST;
                    end else begin
                        nr  = nr_ext[ROW_W-1:0];
                    end
                    next_set = 1'b1;
                    nxt_col  = nc;
                    nxt_row  = nr;
                    if (!item_reg.keep_cursor) begin
                        ncur_col = nc;
                        ncur_row = nr;
                    end
                end
            end
            tcw_pkg::KIND_CLEAR: begin
                clr      = 1'b1;
                ncur_col = '0;
                ncur_row = '0;
            end
            tcw_pkg::KIND_READ: begin
                ac = item_reg.column;
                ar = item_reg.row;
                if (in_range) begin
                    rd = 1'b1;
                end else begin
                    perr     = 1'b1;
                    next_set = 1'b1;
                    nxt_col  = item_reg.column;
                    nxt_row  = item_reg.row;
                end
            end
            tcw_pkg::KIND_SET_CUR: begin
                if (in_range) begin
                    ncur_col = item_reg.column;
                    ncur_row = item_reg.row;
                end else begin
                    perr     = 1'b1;
                    next_set = 1'b1;
                    nxt_col  = item_reg.column;
                    nxt_row  = item_reg.row;
                end
            end
            tcw_pkg::KIND_BACKSPACE: begin
                if (cur_col_reg != '0 || cur_row_reg != '0) begin
                    ac       = bc;
                    ar       = br;
                    wr       = 1'b1;
                    wdata    = {wattr, tcw_pkg::CHAR_SPACE};
                    ncur_col = bc;
                    ncur_row = br;
                end
            end
            default: ;
        endcase
        if (!next_set) begin
            nxt_col = ncur_col;
            nxt_row = ncur_row;
        end
    end

    assign addr_calc = ADDR_W'(ar) * ADDR_W'(COLUMNS) + ADDR_W'(ac);

    always_ff @(posedge aclk) begin
        if (cmd.plan) begin
            addr_reg         <= addr_calc;
            wdata_reg        <= wdata;
            plan_perr_reg    <= perr;
            plan_cur_col_reg <= ncur_col;
            plan_cur_row_reg <= ncur_row;
            plan_nxt_col_reg <= nxt_col;
            plan_nxt_row_reg <= nxt_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plan_wr_reg     <= 1'b0;
            plan_rd_reg     <= 1'b0;
            plan_clear_reg  <= 1'b0;
            plan_scroll_reg <= 1'b0;
        end else if (cmd.plan) begin
            plan_wr_reg     <= wr;
            plan_rd_reg     <= rd;
            plan_clear_reg  <= clr;
            plan_scroll_reg <= scr;
        end
    end

    always_comb begin
        we        = 1'b0;
        waddr     = idx_reg;
        mem_wdata = '0;
        re        = 1'b0;
        raddr     = addr_reg;
        walk_step = 1'b0;
        unique case (cmd.mem_op)
            tcw_pkg::MEM_EXEC: begin
                we        = plan_wr_reg;
                waddr     = addr_reg;
                mem_wdata = wdata_reg;
                re        = plan_rd_reg;
            end
            tcw_pkg::MEM_FILL: begin
                we        = 1'b1;
                mem_wdata = cmd.fill_blank ? {cfg.default_attr, tcw_pkg::CHAR_SPACE} : '0;
                walk_step = 1'b1;
            end
            tcw_pkg::MEM_SCROLL_PRIME: begin
                re    = 1'b1;
                raddr = ADDR_ROW1;
            end
            tcw_pkg::MEM_SCROLL: begin
                we        = 1'b1;
                mem_wdata = (idx_reg < ADDR_SHIFT) ? rdata_reg : '0;
                re        = idx_reg < ADDR_PREF;
                raddr     = idx_reg + ADDR_AHEAD;
                walk_step = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= mem_wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (walk_step) begin
            idx_reg <= (idx_reg == ADDR_LAST) ? '0 : idx_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                cur_col_reg <= plan_cur_col_reg;
                cur_row_reg <= plan_cur_row_reg;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            result_reg.cursor_column  <= plan_cur_col_reg;
            result_reg.cursor_row     <= plan_cur_row_reg;
            result_reg.next_column    <= plan_nxt_col_reg;
            result_reg.next_row       <= plan_nxt_row_reg;
            result_reg.cell_char      <= plan_rd_reg ? rdata_reg[7:0] : '0;
            result_reg.cell_attr      <= plan_rd_reg ? rdata_reg[15:8] : '0;
            result_reg.position_error <= plan_perr_reg;
            result_reg.scrolled       <= plan_scroll_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign result         = result_reg;
    assign st.plan_clear  = plan_clear_reg;
    assign st.plan_scroll = plan_scroll_reg;
    assign st.walk_last   = (idx_reg == ADDR_LAST);
    assign st.out_busy    = m_valid_reg && !m_ready;

endmodule

// File: rtl/tcw_ctrl.sv
`include "text_console_writer_core_defines.svh"

module tcw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tcw_pkg::dp_status_t  st,
    output tcw_pkg::ctrl_cmd_t   cmd
);

    localparam logic [2:0] ST_INIT         = 3'd0;
    localparam logic [2:0] ST_IDLE         = 3'd1;
    localparam logic [2:0] ST_DECODE       = 3'd2;
    localparam logic [2:0] ST_EXEC         = 3'd3;
    localparam logic [2:0] ST_FILL         = 3'd4;
    localparam logic [2:0] ST_SCROLL_PRIME = 3'd5;
    localparam logic [2:0] ST_SCROLL       = 3'd6;
    localparam logic [2:0] ST_DONE         = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.mem_op = tcw_pkg::MEM_FILL;
                if (st.walk_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.plan   = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.mem_op = tcw_pkg::MEM_EXEC;
                if (st.plan_clear) begin
                    state_next = ST_FILL;
                end else if (st.plan_scroll) begin
                    state_next = ST_SCROLL_PRIME;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_FILL: begin
                cmd.mem_op     = tcw_pkg::MEM_FILL;
                cmd.fill_blank = 1'b1;
                if (st.walk_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL_PRIME: begin
                cmd.mem_op = tcw_pkg::MEM_SCROLL_PRIME;
                state_next = ST_SCROLL;
            end
            ST_SCROLL: begin
                cmd.mem_op = tcw_pkg::MEM_SCROLL;
                if (st.walk_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!st.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    `TCW_ASSERT_HOLDS(a_init_blocks_input, aclk, aresetn, state_reg == ST_INIT, !in_ready, "item accepted during clearing pass")
    `TCW_ASSERT_NEXT(a_accept_decodes, aclk, aresetn, in_valid && in_ready, state_reg == ST_DECODE, "accepted item not decoded")
    `TCW_ASSERT_NEXT(a_result_held, aclk, aresetn, state_reg == ST_DONE && st.out_busy, state_reg == ST_DONE, "result dropped while output busy")
    `TCW_ASSERT_NEXT(a_scroll_ends, aclk, aresetn, state_reg == ST_SCROLL && st.walk_last, state_reg == ST_DONE, "scroll walk overran")

endmodule

// File: rtl/text_console_writer_core.sv
// Channel   | Direction | Beat contents
// s_ (item) | in        | tuser: kind; tdata: char_code, column, row, use_position, keep_cursor
// m_ (res)  | out       | tdata: cursor, next position, cell char/attr, error, scrolled
// apb       | cfg       | text_attribute @0x0, default_attribute @0x4, error_attribute @0x8
//
// From acceptance to the next ready an item passes through accept, decode and
// address multiply, one cell store access and result load.
// Scroll adds a priming read and a walk of every cell, clear the walk; one cell per cycle.
// After reset a clearing pass over all cells zeroes the store; s_tready stays low.
// A result waits in the output register; the next item runs up to its result load
// and holds there until m_tready takes the waiting beat.
module text_console_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [7:0] char_code, [14:8] column, [19:15] row, [20] use_position,
    // [21] keep_cursor, [23:22] zero
    input  logic [23:0]                     s_tdata,
    // [2:0] kind
    input  logic [2:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [6:0] cursor_column, [11:7] cursor_row, [18:12] next_column, [23:19] next_row,
    // [31:24] cell_char, [39:32] cell_attr, [40] position_error, [41] scrolled,
    // [47:42] zero
    output logic [47:0]                     m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    tcw_pkg::cfg_t       cfg;
    tcw_pkg::item_t      item;
    tcw_pkg::ctrl_cmd_t  cmd;
    tcw_pkg::dp_status_t st;
    tcw_pkg::result_t    result;

    assign item.kind         = s_tuser;
    assign item.char_code    = s_tdata[7:0];
    assign item.column       = s_tdata[14:8];
    assign item.row          = s_tdata[19:15];
    assign item.use_position = s_tdata[20];
    assign item.keep_cursor  = s_tdata[21];

    tcw_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item),
        .cmd     (cmd),
        .st      (st),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .result  (result)
    );

    assign m_tdata = {6'd0, result.scrolled, result.position_error, result.cell_attr,
                      result.cell_char, result.next_row, result.next_column,
                      result.cursor_row, result.cursor_column};

endmodule

// File: tb/text_console_writer_core_test.sv
module text_console_writer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int COL_W      = tcw_pkg::COL_W;
    localparam int ROW_W      = tcw_pkg::ROW_W;
    localparam int CHAR_W     = tcw_pkg::CHAR_W;
    localparam int ATTR_W     = tcw_pkg::ATTR_W;
    localparam int KIND_W     = tcw_pkg::KIND_W;
    localparam int CELL_W     = tcw_pkg::CELL_W;
    localparam int APB_ADDR_W = tcw_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = tcw_pkg::APB_DATA_W;

    localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLUMNS - 1);
    localparam logic [COL_W-1:0] COL_OUT = COL_W'(COLUMNS);
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS - 1);
    localparam logic [ROW_W-1:0] ROW_PEN = ROW_W'(ROWS - 2);
    localparam logic [ROW_W-1:0] ROW_OUT = ROW_W'(ROWS);

    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;
    localparam logic [1:0]        REG_UNUSED     = 2'd3;

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int CYCLE_LIMIT     = 1700 * (CELLS + 64) * 4;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata  = '0;
    logic [2:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [47:0]           m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic [CELL_W-1:0] screen_cells [CELLS];
    int unsigned       cursor_pos;
    logic [ATTR_W-1:0] text_attr;
    logic [ATTR_W-1:0] default_attr;
    logic [ATTR_W-1:0] error_attr;

    tcw_pkg::result_t expected_results [$];
    int               mismatch_count = 0;
    int               cycle_count    = 0;
    logic             no_idle        = 1'b0;

    text_console_writer_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 20);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("text_console_writer_core regression: fail");
            $finish;
        end
    end

    function automatic string show_result(tcw_pkg::result_t r);
        return $sformatf("cursor %0d,%0d next %0d,%0d cell %02h/%02h err %0b scroll %0b",
                         r.cursor_column, r.cursor_row, r.next_column, r.next_row,
                         r.cell_char, r.cell_attr, r.position_error, r.scrolled);
    endfunction

    task automatic note_mismatch(input string msg);
        if (mismatch_count < 10) $display("%s", msg);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : check_results
        tcw_pkg::result_t got;
        tcw_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = tcw_pkg::result_t'(m_tdata[41:0]);
            if (expected_results.size() == 0) begin
                note_mismatch({"unexpected result beat: ", show_result(got)});
            end else begin
                want = expected_results.pop_front();
                if (got !== want || m_tdata[47:42] !== '0) begin
                    note_mismatch({"result mismatch: expected ", show_result(want),
                                   " got ", show_result(got),
                                   $sformatf(" pad %02h", m_tdata[47:42])});
                end
            end
        end
    end

    task automatic reset_console;
        for (int i = 0; i < CELLS; i++) screen_cells[i] = '0;
        cursor_pos   = 0;
        text_attr    = tcw_pkg::TEXT_ATTR_RST;
        default_attr = tcw_pkg::DEFAULT_ATTR_RST;
        error_attr   = tcw_pkg::ERROR_ATTR_RST;
    endtask

    task automatic scroll_console;
        for (int i = 0; i < CELLS - COLUMNS; i++) screen_cells[i] = screen_cells[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_cells[i] = '0;
    endtask

    task automatic console_apply(input tcw_pkg::item_t it, output tcw_pkg::result_t r);
        int unsigned       pos;
        int unsigned       old_cur;
        logic              in_range;
        logic              next_set;
        logic [ATTR_W-1:0] wattr;
        r        = '0;
        next_set = 1'b0;
        in_range = (it.column < COLUMNS) && (it.row < ROWS);
        wattr    = (text_attr != '0) ? text_attr : default_attr;
        case (it.kind)
            tcw_pkg::KIND_PUT: begin
                old_cur = cursor_pos;
                if (it.use_position && !in_range) begin
                    screen_cells[CELLS-1] = {error_attr, tcw_pkg::CHAR_ERROR};
                    r.position_error = 1'b1;
                    r.next_column    = it.column;
                    r.next_row       = it.row;
                    next_set         = 1'b1;
                end else begin
                    pos = it.use_position ? it.row * COLUMNS + it.column : cursor_pos;
                    if (it.char_code == tcw_pkg::CHAR_NEWLINE) begin
                        pos = (pos / COLUMNS + 1) * COLUMNS;
                    end else if (it.char_code == tcw_pkg::CHAR_BACKSPACE) begin
                        screen_cells[pos] = {wattr, tcw_pkg::CHAR_SPACE};
                    end else begin
                        screen_cells[pos] = {wattr, it.char_code};
                        pos++;
                    end
                    if (pos >= CELLS) begin
                        scroll_console();
                        pos -= COLUMNS;
                        r.scrolled = 1'b1;
                    end
                    r.next_column = COL_W'(pos % COLUMNS);
                    r.next_row    = ROW_W'(pos / COLUMNS);
                    next_set      = 1'b1;
                    cursor_pos    = it.keep_cursor ? old_cur : pos;
                end
            end
            tcw_pkg::KIND_CLEAR: begin
                for (int i = 0; i < CELLS; i++) begin
                    screen_cells[i] = {default_attr, tcw_pkg::CHAR_SPACE};
                end
                cursor_pos = 0;
            end
            tcw_pkg::KIND_READ: begin
                if (in_range) begin
                    {r.cell_attr, r.cell_char} = screen_cells[it.row * COLUMNS + it.column];
                end else begin
                    r.position_error = 1'b1;
                    r.next_column    = it.column;
                    r.next_row       = it.row;
                    next_set         = 1'b1;
                end
            end
            tcw_pkg::KIND_SET_CUR: begin
                if (in_range) begin
                    cursor_pos = it.row * COLUMNS + it.column;
                end else begin
                    r.position_error = 1'b1;
                    r.next_column    = it.column;
                    r.next_row       = it.row;
                    next_set         = 1'b1;
                end
            end
            tcw_pkg::KIND_BACKSPACE: begin
                if (cursor_pos != 0) begin
                    cursor_pos--;
                    screen_cells[cursor_pos] = {wattr, tcw_pkg::CHAR_SPACE};
                end
            end
            default: ;
        endcase
        r.cursor_column = COL_W'(cursor_pos % COLUMNS);
        r.cursor_row    = ROW_W'(cursor_pos / COLUMNS);
        if (!next_set) begin
            r.next_column = r.cursor_column;
            r.next_row    = r.cursor_row;
        end
    endtask

    function automatic tcw_pkg::item_t make_item(logic [KIND_W-1:0] k, logic [CHAR_W-1:0] ch,
                                                 logic [COL_W-1:0] col, logic [ROW_W-1:0] rw,
                                                 logic use_pos, logic keep);
        tcw_pkg::item_t it;
        it.kind         = k;
        it.char_code    = ch;
        it.column       = col;
        it.row          = rw;
        it.use_position = use_pos;
        it.keep_cursor  = keep;
        return it;
    endfunction

    task automatic send_item(input tcw_pkg::item_t it);
        tcw_pkg::result_t r;
        while (!no_idle && $urandom_range(0, 99) < 20) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {2'b00, it.keep_cursor, it.use_position, it.row, it.column, it.char_code};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        console_apply(it, r);
        expected_results.push_back(r);
    endtask

    task automatic settle_block;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [ATTR_W-1:0] value);
        logic [APB_DATA_W-1:0] word;
        word       = $urandom();
        word[7:0]  = value;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            tcw_pkg::REG_TEXT_ATTR:    text_attr    = value;
            tcw_pkg::REG_DEFAULT_ATTR: default_attr = value;
            tcw_pkg::REG_ERROR_ATTR:   error_attr   = value;
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [ATTR_W-1:0] pick_attr();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return ATTR_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic tcw_pkg::item_t random_item();
        tcw_pkg::item_t it;
        int unsigned    pick;
        int unsigned    prev;
        it.char_code    = CHAR_W'($urandom_range(0, 255));
        it.column       = COL_W'($urandom_range(0, COLUMNS - 1));
        it.row          = ROW_W'($urandom_range(0, ROWS - 1));
        it.use_position = $urandom_range(0, 9) < 3;
        it.keep_cursor  = $urandom_range(0, 4) == 0;
        if ($urandom_range(0, 9) == 0) begin
            it.column = COL_W'($urandom_range(0, 127));
            it.row    = ROW_W'($urandom_range(0, 31));
        end
        pick = $urandom_range(0, 99);
        if (pick < 57) begin
            it.kind = tcw_pkg::KIND_PUT;
            case ($urandom_range(0, 19))
                0, 1:    it.char_code = tcw_pkg::CHAR_NEWLINE;
                2:       it.char_code = tcw_pkg::CHAR_BACKSPACE;
                default: ;
            endcase
        end else if (pick < 69) begin
            it.kind = tcw_pkg::KIND_SET_CUR;
        end else if (pick < 84) begin
            it.kind = tcw_pkg::KIND_READ;
            if ($urandom_range(0, 1) == 1 && cursor_pos != 0) begin
                prev      = cursor_pos - 1;
                it.column = COL_W'(prev % COLUMNS);
                it.row    = ROW_W'(prev / COLUMNS);
            end
        end else if (pick < 96) begin
            it.kind = tcw_pkg::KIND_BACKSPACE;
        end else if (pick < 98) begin
            it.kind = tcw_pkg::KIND_CLEAR;
        end else begin
            it.kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        end
        return it;
    endfunction

    task automatic test_directed_edits;
        send_item(make_item(tcw_pkg::KIND_READ, 8'h00, 7'd0, 5'd0, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_PUT, 8'h41, 7'd0, 5'd0, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_PUT, 8'hFF, 7'd0, 5'd0, 1'b0, 1'b1));
        send_item(make_item(tcw_pkg::KIND_PUT, 8'h00, 7'd0, 5'd0, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_PUT, tcw_pkg::CHAR_BACKSPACE, 7'd0, 5'd0, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_PUT, tcw_pkg::CHAR_NEWLINE, 7'd0, 5'd0, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_READ, 8'h00, 7'd1, 5'd0, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_PUT, 8'h5A, COL_MAX, ROW_MAX, 1'b1, 1'b0));
        send_item(make_item(tcw_pkg::KIND_READ, 8'h00, COL_MAX, ROW_PEN, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_PUT, 8'h31, COL_OUT, 5'd0, 1'b1, 1'b0));
        send_item(make_item(tcw_pkg::KIND_PUT, 8'h32, 7'd127, 5'd31, 1'b1, 1'b1));
        send_item(make_item(tcw_pkg::KIND_PUT, 8'h33, 7'd0, ROW_OUT, 1'b1, 1'b0));
        send_item(make_item(tcw_pkg::KIND_READ, 8'h00, COL_MAX, ROW_MAX, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_READ, 8'hFF, 7'd127, 5'd31, 1'b1, 1'b1));
        send_item(make_item(tcw_pkg::KIND_SET_CUR, 8'h00, 7'd127, 5'd31, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_SET_CUR, 8'h00, COL_MAX, ROW_MAX, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_PUT, tcw_pkg::CHAR_NEWLINE, 7'd0, 5'd0, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_SET_CUR, 8'h00, 7'd0, 5'd0, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_BACKSPACE, 8'h00, 7'd0, 5'd0, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_PUT, 8'h78, 7'd0, 5'd0, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_BACKSPACE, 8'hFF, 7'd127, 5'd31, 1'b1, 1'b1));
        send_item(make_item(tcw_pkg::KIND_CLEAR, 8'h00, 7'd0, 5'd0, 1'b0, 1'b0));
        send_item(make_item(KIND_UNUSED_LO, 8'hFF, 7'd127, 5'd31, 1'b1, 1'b1));
        send_item(make_item(KIND_UNUSED_LO + 3'd1, 8'h0A, 7'd3, 5'd2, 1'b0, 1'b0));
        send_item(make_item(KIND_UNUSED_HI, 8'h08, 7'd0, 5'd0, 1'b1, 1'b0));
        send_item(make_item(tcw_pkg::KIND_READ, 8'h00, 7'd0, 5'd0, 1'b0, 1'b0));
    endtask

    task automatic test_attribute_extremes;
        settle_block();
        write_register(tcw_pkg::REG_TEXT_ATTR, 8'h00);
        write_register(tcw_pkg::REG_DEFAULT_ATTR, 8'hFF);
        write_register(tcw_pkg::REG_ERROR_ATTR, 8'h00);
        write_register(REG_UNUSED, 8'h5A);
        send_item(make_item(tcw_pkg::KIND_PUT, 8'h61, 7'd0, 5'd0, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_PUT, 8'h62, 7'd100, 5'd3, 1'b1, 1'b0));
        send_item(make_item(tcw_pkg::KIND_READ, 8'h00, 7'd0, 5'd0, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_READ, 8'h00, COL_MAX, ROW_MAX, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_CLEAR, 8'h00, 7'd0, 5'd0, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_READ, 8'h00, 7'd5, 5'd5, 1'b0, 1'b0));
        settle_block();
        write_register(tcw_pkg::REG_TEXT_ATTR, 8'hFF);
        write_register(tcw_pkg::REG_DEFAULT_ATTR, 8'h00);
        write_register(tcw_pkg::REG_ERROR_ATTR, 8'hFF);
        send_item(make_item(tcw_pkg::KIND_PUT, 8'h62, 7'd0, 5'd0, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_PUT, 8'h63, 7'd0, 5'd0, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_BACKSPACE, 8'h00, 7'd0, 5'd0, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_READ, 8'h00, 7'd1, 5'd0, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_PUT, 8'h64, 7'd0, 5'd31, 1'b1, 1'b0));
        send_item(make_item(tcw_pkg::KIND_READ, 8'h00, COL_MAX, ROW_MAX, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_CLEAR, 8'h00, 7'd0, 5'd0, 1'b0, 1'b0));
        send_item(make_item(tcw_pkg::KIND_READ, 8'h00, 7'd1, 5'd1, 1'b0, 1'b0));
    endtask

    task automatic test_random_traffic;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle_block();
            write_register(tcw_pkg::REG_TEXT_ATTR, pick_attr());
            write_register(tcw_pkg::REG_DEFAULT_ATTR, pick_attr());
            write_register(tcw_pkg::REG_ERROR_ATTR, pick_attr());
            no_idle = (phase == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_item(random_item());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        reset_console();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_edits();
        test_attribute_extremes();
        test_random_traffic();
        settle_block();
        if (mismatch_count == 0) begin
            $display("text_console_writer_core regression: pass");
        end else begin
            $display("text_console_writer_core regression: fail");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_regs.sv
rtl/tcw_datapath.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer_core.sv
tb/text_console_writer_core_test.sv
